// File: rtl/slrr_pkg.sv
// ---------------------------------------------------------------------------
// Sine-law rudder regulator package
// Shared widths, codes, defaults and the quarter-wave sine evaluation used to
// build the sine ROM at elaboration.
// ---------------------------------------------------------------------------
`default_nettype none

package slrr_pkg;

   localparam int unsigned FUNC_W     = 2;
   localparam int unsigned HEADING_W  = 12;
   localparam int unsigned SPEED_W    = 16;
   localparam int unsigned RUDDER_W   = 10;
   localparam int unsigned ANGLE_W    = 11;
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 16;

   localparam int unsigned UNITS_PER_TURN_DEF     = 3600;
   localparam int unsigned SINE_FRACTION_BITS_DEF = 15;

   localparam logic [HEADING_W-1:0] HEADING_UNKNOWN  = 12'd3700;
   localparam logic [RUDDER_W-1:0]  MAX_RUDDER_RESET = 10'd300;

   localparam logic [63:0] Q30_ONE    = 64'd1073741824;
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STATE  = 2'd0,
      FUNC_COURSE = 2'd1,
      FUNC_TICK   = 2'd2
   } func_type;

   // sin(t), t in Q30 radians (0..pi/2), Taylor series to t^9 in Horner form,
   // rounded to frac_bits fraction bits. Only called with constant arguments.
   function automatic logic [63:0] quarter_sine(input logic [63:0] t,
                                                 input int unsigned frac_bits);
      logic [63:0] t2;
      logic [63:0] p;
      logic [63:0] s;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      p  = Q30_ONE;
      p  = Q30_ONE - ((((t2 * p) >> 30) + 64'd36) / 64'd72);
      p  = Q30_ONE - ((((t2 * p) >> 30) + 64'd21) / 64'd42);
      p  = Q30_ONE - ((((t2 * p) >> 30) + 64'd10) / 64'd20);
      p  = Q30_ONE - ((((t2 * p) >> 30) + 64'd3) / 64'd6);
      s  = (t * p) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
   endfunction

endpackage

`default_nettype wire

// File: rtl/slrr_sine_rom.sv
// ---------------------------------------------------------------------------
// Quarter-wave sine ROM
// Entry r holds sin(2*pi*r/U) for r = 0..U/4, rounded; registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module slrr_sine_rom #(
   parameter int unsigned UNITS_PER_TURN     = slrr_pkg::UNITS_PER_TURN_DEF,
   parameter int unsigned SINE_FRACTION_BITS = slrr_pkg::SINE_FRACTION_BITS_DEF,
   localparam int unsigned DEPTH  = UNITS_PER_TURN / 4 + 1,
   localparam int unsigned ADDR_W = $clog2(DEPTH),
   localparam int unsigned SINE_W = SINE_FRACTION_BITS + 1
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [ADDR_W-1:0] addr,
   output logic      [SINE_W-1:0] data
);

   logic [SINE_W-1:0] rom_w [DEPTH];
   logic [SINE_W-1:0] data_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_entry
      localparam logic [63:0] ANGLE_Q30 =
         (64'(i) * slrr_pkg::TWO_PI_Q30 + 64'(UNITS_PER_TURN / 2)) / 64'(UNITS_PER_TURN);
      assign rom_w[i] = SINE_W'(slrr_pkg::quarter_sine(ANGLE_Q30, SINE_FRACTION_BITS));
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= rom_w[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// File: rtl/sine_law_rudder_regulator.sv
// ---------------------------------------------------------------------------
// Sine-law rudder regulator
// Heading/course/speed state plus a three-stage rudder command pipeline.
// ---------------------------------------------------------------------------
// Takes one transaction per clock. State and course transactions update the
// stored vessel heading, speed sign and desired heading (tenths of a degree,
// 3700 = unknown) and produce nothing. A tick transaction produces one rudder
// command. Stage 1 registers the heading error modulo one turn at the edge
// that takes the tick. Stage 2 is the registered read of the quarter-wave
// sine ROM (UNITS_PER_TURN/4 + 1 entries), addressed from the stage 1
// register. Stage 3 scales by the rudder limit with one multiply and applies
// the sign into the output register, which drives rsp_tvalid. Everything
// advances together, so back-to-back ticks flow at one per clock. The
// pipeline stalls only while a finished command sits in the output register
// and rsp_tready is low. Write csr_data only while no tick is in flight; the
// register is read live by the last stage.
// ---------------------------------------------------------------------------
`default_nettype none

module sine_law_rudder_regulator #(
   parameter int unsigned UNITS_PER_TURN     = slrr_pkg::UNITS_PER_TURN_DEF,
   parameter int unsigned SINE_FRACTION_BITS = slrr_pkg::SINE_FRACTION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [1:0] func, [13:2] heading_value, [29:14] vessel_speed, [31:30] zero
   input  wire logic [slrr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [10:0] rudder_angle, [15:11] zero
   output logic      [slrr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration write: rudder limit, tenths of a degree
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [slrr_pkg::RUDDER_W-1:0]     csr_data
);

   localparam int unsigned HEAD_W      = slrr_pkg::HEADING_W;
   localparam int unsigned HW          = $clog2(UNITS_PER_TURN);  // reduced heading width
   localparam int unsigned QDEPTH      = UNITS_PER_TURN / 4 + 1;
   localparam int unsigned ADDR_W      = $clog2(QDEPTH);
   localparam int unsigned SINE_W      = SINE_FRACTION_BITS + 1;
   localparam int unsigned RUD_W       = slrr_pkg::RUDDER_W;
   localparam int unsigned ANG_W       = slrr_pkg::ANGLE_W;
   localparam int unsigned PROD_W      = SINE_W + RUD_W;
   // modulo-by-constant via reciprocal multiply; quotient is exact or one low
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / UNITS_PER_TURN;
   localparam int unsigned RECIP_W     = $clog2(RECIP + 1);
   localparam int unsigned RPROD_W     = HEAD_W + RECIP_W;

   typedef struct packed {
      logic zero;      // command forced to 0
      logic negative;  // speed sign times sine sign is negative
      logic full;      // cosine negative: full rudder
   } cmd_flags_type;

   // ---------------- handshake / stall ----------------
   logic pipe_en;
   logic req_accept;

   assign pipe_en    = !rsp_tvalid || rsp_tready;
   assign req_tready = pipe_en;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // ---------------- request fields ----------------
   slrr_pkg::func_type           req_func;
   logic [HEAD_W-1:0]            req_heading;
   logic [slrr_pkg::SPEED_W-1:0] req_speed;

   assign req_func    = slrr_pkg::func_type'(req_tdata[1:0]);
   assign req_heading = req_tdata[13:2];
   assign req_speed   = req_tdata[29:14];

   // ---------------- config register ----------------
   logic [RUD_W-1:0] max_rudder_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_rudder_ff <= slrr_pkg::MAX_RUDDER_RESET;
      end else if (csr_valid && csr_ready) begin
         max_rudder_ff <= csr_data;
      end
   end

   // ---------------- heading reduction mod one turn ----------------
   logic [RPROD_W-1:0] recip_prod;
   logic [HEAD_W-1:0]  quot;
   logic [HEAD_W-1:0]  quot_units;
   logic [HEAD_W-1:0]  rem_raw;
   logic [HEAD_W-1:0]  rem_fix;
   logic [HW-1:0]      heading_reduced;

   assign recip_prod      = RPROD_W'(req_heading) * RPROD_W'(RECIP);
   assign quot            = HEAD_W'(recip_prod >> RECIP_SHIFT);
   assign quot_units      = HEAD_W'(quot * UNITS_PER_TURN);  // never exceeds the heading
   assign rem_raw         = req_heading - quot_units;
   assign rem_fix         = (rem_raw >= UNITS_PER_TURN) ?
                            rem_raw - HEAD_W'(UNITS_PER_TURN) : rem_raw;
   assign heading_reduced = HW'(rem_fix);

   // ---------------- stored state ----------------
   logic [HW-1:0] vessel_heading_ff;
   logic [HW-1:0] desired_heading_ff;
   logic          vessel_known_ff;
   logic          desired_known_ff;
   logic          speed_nonzero_ff;
   logic          speed_negative_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vessel_known_ff   <= 1'b0;
         desired_known_ff  <= 1'b0;
         speed_nonzero_ff  <= 1'b0;
         speed_negative_ff <= 1'b0;
      end else if (req_accept) begin
         case (req_func)
            slrr_pkg::FUNC_STATE: begin
               vessel_known_ff   <= req_heading != slrr_pkg::HEADING_UNKNOWN;
               speed_nonzero_ff  <= |req_speed;
               speed_negative_ff <= req_speed[slrr_pkg::SPEED_W-1];
            end
            slrr_pkg::FUNC_COURSE: begin
               desired_known_ff <= req_heading != slrr_pkg::HEADING_UNKNOWN;
            end
            default: begin
            end
         endcase
      end
   end

   // heading payloads: known flags above gate their meaning
   always_ff @(posedge clock) begin
      if (req_accept && req_func == slrr_pkg::FUNC_STATE) begin
         vessel_heading_ff <= heading_reduced;
      end
      if (req_accept && req_func == slrr_pkg::FUNC_COURSE) begin
         desired_heading_ff <= heading_reduced;
      end
   end

   // ---------------- stage 1: heading error ----------------
   logic [HW:0]   diff;
   logic [HW-1:0] error_in;
   logic          zero1_in;
   logic          tick_accept;

   logic          s1_valid_ff;
   logic [HW-1:0] error_ff;
   logic          zero1_ff;
   logic          negspeed1_ff;

   assign diff        = {1'b0, vessel_heading_ff} - {1'b0, desired_heading_ff};
   assign error_in    = diff[HW] ? HW'(diff + (HW+1)'(UNITS_PER_TURN)) : diff[HW-1:0];
   assign zero1_in    = !vessel_known_ff || !desired_known_ff || !speed_nonzero_ff;
   assign tick_accept = req_accept && req_func == slrr_pkg::FUNC_TICK;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff <= tick_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         error_ff     <= error_in;
         zero1_ff     <= zero1_in;
         negspeed1_ff <= speed_negative_ff;
      end
   end

   // ---------------- stage 2: quadrant and sine lookup ----------------
   logic [HW+1:0]     err_x2;
   logic [HW+1:0]     err_x4;
   logic [HW+1:0]     turn_x1;
   logic [HW+1:0]     turn_x3;
   logic              sine_zero;
   logic              sine_pos;
   logic              cos_neg;
   logic [HW-1:0]     reduced_arg;
   cmd_flags_type     flags2_in;

   logic              s2_valid_ff;
   cmd_flags_type     flags2_ff;
   logic [SINE_W-1:0] sine;

   assign err_x2      = {1'b0, error_ff, 1'b0};
   assign err_x4      = {error_ff, 2'b00};
   assign turn_x1     = (HW+2)'(UNITS_PER_TURN);
   assign turn_x3     = (HW+2)'(3 * UNITS_PER_TURN);
   assign sine_zero   = (error_ff == '0) || (err_x2 == turn_x1);
   assign sine_pos    = err_x2 < turn_x1;
   assign cos_neg     = (err_x4 > turn_x1) && (err_x4 < turn_x3);
   // fold into the first quadrant; only used when the cosine is not negative
   assign reduced_arg = (err_x4 <= turn_x1) ? error_ff : HW'(UNITS_PER_TURN) - error_ff;

   assign flags2_in.zero     = zero1_ff || sine_zero;
   assign flags2_in.negative = negspeed1_ff ^ !sine_pos;
   assign flags2_in.full     = cos_neg;

   slrr_sine_rom #(
      .UNITS_PER_TURN     (UNITS_PER_TURN),
      .SINE_FRACTION_BITS (SINE_FRACTION_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .enable (pipe_en),
      .addr   (ADDR_W'(reduced_arg)),
      .data   (sine)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         flags2_ff <= flags2_in;
      end
   end

   // ---------------- stage 3: scale, sign, output register ----------------
   logic [PROD_W-1:0]       scaled;
   logic [RUD_W-1:0]        sine_mag;
   logic [RUD_W-1:0]        mag;
   logic signed [ANG_W-1:0] angle_in;

   logic                    rsp_valid_ff;
   logic signed [ANG_W-1:0] angle_ff;

   // round half up; s <= 1.0 keeps the result within the rudder limit
   assign scaled   = PROD_W'(sine) * PROD_W'(max_rudder_ff)
                   + (PROD_W'(1) << (SINE_FRACTION_BITS - 1));
   assign sine_mag = RUD_W'(scaled >> SINE_FRACTION_BITS);
   assign mag      = flags2_ff.full ? max_rudder_ff : sine_mag;

   always_comb begin
      if (flags2_ff.zero) begin
         angle_in = '0;
      end else if (flags2_ff.negative) begin
         angle_in = -$signed({1'b0, mag});
      end else begin
         angle_in = $signed({1'b0, mag});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(slrr_pkg::RSP_DATA_W - ANG_W){1'b0}}, angle_ff};

   // ---------------- assertions ----------------
   // command never exceeds the configured limit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (angle_ff <= $signed({1'b0, max_rudder_ff}) &&
                        angle_ff >= -$signed({1'b0, max_rudder_ff})))
      else $error("rudder command beyond the rudder limit");

   // a non-zero full-rudder case lands exactly on the limit
   assert property (@(posedge clock) disable iff (reset)
      (pipe_en && s2_valid_ff && flags2_ff.full && !flags2_ff.zero) |=>
         (angle_ff == $signed({1'b0, max_rudder_ff}) ||
          angle_ff == -$signed({1'b0, max_rudder_ff})))
      else $error("full rudder command does not equal the limit");

   // a forced-zero command comes out as zero
   assert property (@(posedge clock) disable iff (reset)
      (pipe_en && s2_valid_ff && flags2_ff.zero) |=> (rsp_valid_ff && angle_ff == '0))
      else $error("zeroed command not zero at output");

endmodule

`default_nettype wire

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// Sine-law rudder regulator testbench
// Streams state, course, tick and unused-code transactions into the block
// while randomly stalling both stream sides. A local predictor tracks the
// stored headings, the speed sign and the rudder limit, and works out each
// rudder command. Every response transaction is checked against the oldest
// pending prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

   import slrr_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;   // code the block must ignore
   localparam int unsigned TURN      = UNITS_PER_TURN_DEF;
   localparam int unsigned SINE_FRAC = SINE_FRACTION_BITS_DEF;
   localparam int unsigned PIPE_WAIT = 8;     // three pipeline stages, plus margin
   localparam int unsigned STALL_LIMIT = 4000;

   // ------------------------------------------------------------------
   // DUT connections, all inputs known from time zero
   // ------------------------------------------------------------------
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [1:0] func, [13:2] heading_value, [29:14] vessel_speed, [31:30] zero
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [10:0] rudder_angle, [15:11] zero
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [RUDDER_W-1:0]   csr_data   = '0;

   sine_law_rudder_regulator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Predictor state: a private copy of what the block should hold
   // ------------------------------------------------------------------
   logic [HEADING_W-1:0] vessel_hdg;
   logic [HEADING_W-1:0] desired_hdg;
   int                   speed_sign;
   logic [RUDDER_W-1:0]  max_angle;

   logic [ANGLE_W-1:0] rudder_expected_q[$];   // commands still owed by the block

   int  mismatches     = 0;
   int  requests_sent  = 0;
   int  ticks_checked  = 0;
   int  settings_used  = 1;
   bit  send_idle_on   = 1'b1;   // sender inserts gaps
   bit  recv_idle_on   = 1'b1;   // receiver inserts stalls
   int  recv_stall_left = 0;
   int  quiet_cycles    = 0;

   // Quarter-wave sine for 0 <= r <= TURN/4: Q30 angle, Taylor series to
   // t^9 in Horner form, truncated products, rounded divisions, capped at
   // one, then rounded to SINE_FRAC fraction bits.
   function automatic logic [63:0] sine_q_frac(input logic [63:0] r);
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] divs[4];
      divs = '{64'd72, 64'd42, 64'd20, 64'd6};
      t  = (r * TWO_PI_Q30 + TURN / 2) / TURN;
      t2 = (t * t + (64'd1 << 29)) >> 30;
      p  = Q30_ONE;
      for (int k = 0; k < 4; k++) begin
         p = Q30_ONE - ((((t2 * p) >> 30) + divs[k] / 2) / divs[k]);
      end
      s = (t * p) >> 30;
      if (s > Q30_ONE) begin
         s = Q30_ONE;
      end
      return (s + (64'd1 << (29 - SINE_FRAC))) >> (30 - SINE_FRAC);
   endfunction

   // Rudder command the block should emit for a tick right now.
   function automatic logic [ANGLE_W-1:0] rudder_for_tick();
      logic [63:0] hv;
      logic [63:0] hd;
      logic [63:0] err;
      logic [63:0] r;
      int          sine_sign;
      int          mag;
      int          cmd;
      if (vessel_hdg == HEADING_UNKNOWN || desired_hdg == HEADING_UNKNOWN) begin
         return '0;
      end
      hv  = vessel_hdg % TURN;
      hd  = desired_hdg % TURN;
      err = (hv + TURN - hd) % TURN;
      // sine is zero on the heading and exactly half a turn off it
      if (err == 0 || 2 * err == TURN) begin
         sine_sign = 0;
      end else if (2 * err < TURN) begin
         sine_sign = 1;
      end else begin
         sine_sign = -1;
      end
      if (4 * err > TURN && 4 * err < 3 * TURN) begin
         mag = max_angle;   // cosine negative: full rudder
      end else begin
         r   = (4 * err <= TURN) ? err : TURN - err;
         mag = int'((sine_q_frac(r) * max_angle + (64'd1 << (SINE_FRAC - 1))) >> SINE_FRAC);
      end
      cmd = speed_sign * sine_sign * mag;
      return cmd[ANGLE_W-1:0];
   endfunction

   // Apply one accepted request transaction to the predictor.
   function automatic void predict_request(input logic [FUNC_W-1:0] f,
                                           input logic [HEADING_W-1:0] h,
                                           input logic [SPEED_W-1:0] s);
      case (f)
         FUNC_STATE: begin
            vessel_hdg = h;
            speed_sign = (s == '0) ? 0 : (s[SPEED_W-1] ? -1 : 1);
         end
         FUNC_COURSE: begin
            desired_hdg = h;
         end
         FUNC_TICK: begin
            rudder_expected_q.push_back(rudder_for_tick());
         end
         default: begin
         end
      endcase
   endfunction

   // Gap length: mostly back to back, sometimes short, rarely long.
   function automatic int pick_gap(input bit enabled);
      int roll;
      if (!enabled) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // ------------------------------------------------------------------
   // Request driver. Called at a rising edge; leaves tvalid high after the
   // handshake so a back-to-back transaction needs no extra edge.
   // ------------------------------------------------------------------
   task automatic send_request(input logic [FUNC_W-1:0] f,
                               input logic [HEADING_W-1:0] h,
                               input logic [SPEED_W-1:0] s);
      int gap;
      gap = pick_gap(send_idle_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, s, h, f};
      do @(posedge clock); while (!req_tready);
      predict_request(f, h, s);
      requests_sent++;
   endtask

   // Drop tvalid, let every owed command drain, then give the pipeline time
   // to finish anything that produces no response.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (rudder_expected_q.size() != 0) @(posedge clock);
      repeat (PIPE_WAIT) @(posedge clock);
   endtask

   task automatic write_max_angle(input logic [RUDDER_W-1:0] value);
      drain_block();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_angle = value;
      settings_used++;
   endtask

   function automatic logic [HEADING_W-1:0] rand_heading();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         return HEADING_UNKNOWN;
      end else if (roll < 10) begin
         return HEADING_W'($urandom_range(TURN, 4095));   // out of range, wraps
      end
      return HEADING_W'($urandom_range(0, TURN - 1));
   endfunction

   function automatic logic [SPEED_W-1:0] rand_speed();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         return '0;
      end else if (roll < 14) begin
         return 16'h8000;
      end else if (roll < 18) begin
         return 16'h7FFF;
      end
      return SPEED_W'($urandom);
   endfunction

   // Random traffic. Course updates are often placed at a chosen error from
   // the current vessel heading so that the boundary angles recur.
   task automatic random_traffic(input int count);
      int          roll;
      int          offs[10];
      logic [FUNC_W-1:0]    f;
      logic [HEADING_W-1:0] h;
      offs = '{0, 1, 899, 900, 901, 1800, 2699, 2700, 2701, 3599};
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            f = FUNC_STATE;
         end else if (roll < 55) begin
            f = FUNC_COURSE;
         end else if (roll < 95) begin
            f = FUNC_TICK;
         end else begin
            f = FUNC_UNUSED;
         end
         h = rand_heading();
         if (f == FUNC_COURSE && vessel_hdg != HEADING_UNKNOWN &&
             $urandom_range(0, 99) < 30) begin
            h = HEADING_W'((int'(vessel_hdg % TURN) + TURN - offs[$urandom_range(0, 9)]) % TURN);
         end
         send_request(f, h, rand_speed());
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Hand-picked transactions at the reset value of the rudder limit.
   task automatic test_directed_cases();
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // both headings unknown
      send_request(FUNC_STATE,  12'd0,    16'h7FFF);
      send_request(FUNC_TICK,   12'd4095, 16'hFFFF);   // desired still unknown
      send_request(FUNC_COURSE, 12'd1800, 16'h0000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // half a turn: zero sine
      send_request(FUNC_COURSE, 12'd0,    16'h0000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // on course
      send_request(FUNC_STATE,  12'd900,  16'h8000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // quarter turn, negative speed
      send_request(FUNC_STATE,  12'd2700, 16'h0001);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // three-quarter turn
      send_request(FUNC_STATE,  12'd1,    16'hFFFF);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // smallest error
      send_request(FUNC_STATE,  12'd3599, 16'h0000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // zero speed
      send_request(FUNC_STATE,  12'd4095, 16'h4000);   // out of range vessel heading
      send_request(FUNC_COURSE, 12'd3600, 16'h0000);   // out of range, equals zero
      send_request(FUNC_TICK,   12'd0,    16'h0000);
      send_request(FUNC_STATE,  12'd1000, 16'h0005);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // cosine negative: full rudder
      send_request(FUNC_UNUSED, 12'hFFF,  16'hFFFF);   // ignored code
      send_request(FUNC_COURSE, 12'd3700, 16'h0000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);   // desired unknown again
      send_request(FUNC_COURSE, 12'd300,  16'h0000);
      send_request(FUNC_TICK,   12'd0,    16'h0000);
   endtask

   // Register at zero, at 900 and at its smallest nonzero value.
   task automatic test_config_extremes();
      write_max_angle(10'd0);
      random_traffic(40);
      write_max_angle(10'd900);
      random_traffic(40);
      write_max_angle(10'd1);
      random_traffic(30);
   endtask

   // Long random run: one phase per register setting, each phase with its
   // own idling mix (the first with no idling at all).
   task automatic test_random_traffic();
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_on = (ph != 0) && (ph != 3);
         recv_idle_on = (ph != 0) && (ph != 2);
         write_max_angle(RUDDER_W'($urandom_range(0, 900)));
         random_traffic(135);
      end
      send_idle_on = 1'b1;
      recv_idle_on = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Response side: random back-pressure and the checker
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      logic [ANGLE_W-1:0] want;
      int                 gap;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rudder_expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected rudder transaction: got %0d",
                        $signed(rsp_tdata[ANGLE_W-1:0]));
            end
         end else begin
            want = rudder_expected_q.pop_front();
            ticks_checked++;
            if (rsp_tdata[ANGLE_W-1:0] !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("rudder_angle mismatch: expected %0d, got %0d",
                           $signed(want), $signed(rsp_tdata[ANGLE_W-1:0]));
               end
            end
         end
      end
      if (recv_stall_left > 0) begin
         rsp_tready      <= 1'b0;
         recv_stall_left <= recv_stall_left - 1;
      end else begin
         gap = pick_gap(recv_idle_on);
         rsp_tready      <= (gap == 0);
         recv_stall_left <= (gap > 0) ? gap - 1 : 0;
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      vessel_hdg  = HEADING_UNKNOWN;
      desired_hdg = HEADING_UNKNOWN;
      speed_sign  = 0;
      max_angle   = MAX_RUDDER_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_config_extremes();
      test_random_traffic();

      drain_block();
      $display("Sent %0d request transactions; checked %0d rudder commands",
               requests_sent, ticks_checked);
      $display("over %0d rudder limit settings (reset value, 0, 1, 900, random).",
               settings_used);
      if (mismatches == 0 && rudder_expected_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
